// ===== sv/rope_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rope_pkg
// Types, fixed-point constants and build-time table functions for the
// rotary position embedding pipeline.
// ----------------------------------------------------------------------------
package rope_pkg;

  localparam int unsigned TAB_DEPTH = 64;

  localparam logic [63:0] ONE48      = 64'h0001_0000_0000_0000;
  localparam logic [63:0] F0_TURNS   = 64'd174992710548;
  localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;
  localparam logic [30:0] ONE30      = 31'h4000_0000;
  localparam logic [30:0] HALF_LSB15 = 31'd16384;

  typedef enum logic [1:0] {
    QUAD_0,
    QUAD_1,
    QUAD_2,
    QUAD_3
  } rope_quad_e;

  typedef struct packed {
    logic [19:0]        position;
    logic [5:0]         pair_index;
    logic signed [15:0] x_even;
    logic signed [15:0] x_odd;
  } rope_in_t;

  typedef struct packed {
    logic signed [15:0] y_even;
    logic signed [15:0] y_odd;
  } rope_out_t;

  typedef struct packed {
    rope_quad_e         quad;
    logic               swap;
    logic signed [15:0] x_even;
    logic signed [15:0] x_odd;
  } rope_side_t;

  typedef struct packed {
    rope_side_t  side;
    logic [29:0] x;
    logic [29:0] x2;
    logic [30:0] t_sin;
    logic [30:0] t_cos;
  } rope_trig_t;

  function automatic logic [63:0] mul_shr48(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[111:48];
  endfunction

  // Largest Q0.48 ratio whose n_pairs-fold truncated power stays <= limit.
  function automatic logic [63:0] rope_ratio(input int unsigned n_pairs,
                                             input logic [63:0] limit);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] p;
    int unsigned it;
    int unsigned k;
    lo = '0;
    hi = ONE48;
    for (it = 0; it < 64; it++) begin
      if (hi - lo > 64'd1) begin
        mid = lo + ((hi - lo) >> 1);
        p = ONE48;
        for (k = 0; k < n_pairs; k++) begin
          p = mul_shr48(p, mid);
        end
        if (p <= limit) begin
          lo = mid;
        end else begin
          hi = mid;
        end
      end
    end
    return lo;
  endfunction

  function automatic logic [39:0] rope_freq(input int unsigned idx,
                                            input int unsigned n_pairs,
                                            input logic [63:0] ratio);
    logic [63:0] cur;
    logic [63:0] e;
    int unsigned k;
    cur = ONE48;
    for (k = 0; k < idx; k++) begin
      cur = mul_shr48(cur, ratio);
    end
    e = mul_shr48(cur, F0_TURNS);
    if (idx >= n_pairs) begin
      e = '0;
    end
    return e[39:0];
  endfunction

endpackage

// ===== sv/rotary_position_embedding.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotary_position_embedding
// Rotary position embedding of one interleaved element pair per item:
// phase from position and per-pair frequency, sin/cos, rotate, Q3.12 out.
// ----------------------------------------------------------------------------
//  Channel   Dir   Handshake                Payload
//  item      in    start high, busy low     item_i   (rope_in_t)
//  result    out   result_valid_o strobe    result_o (rope_out_t)
//
//  One item per cycle; most of the pipeline is the chain of
//  multipliers in the sin/cos unit (angle, square, five Horner terms).
//  The frequency table is constant logic built at elaboration: no fill
//  after reset. Reset clears only the stage valid bits.
//  busy stays low; the pipeline never stalls since results are not held off.
// ----------------------------------------------------------------------------
module rotary_position_embedding #(
  parameter int unsigned HALF_DIM  = 64,
  parameter int unsigned ROPE_BASE = 10000
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  rope_pkg::rope_in_t  item_i,
  output logic                result_valid_o,
  output rope_pkg::rope_out_t result_o
);

  logic                 ph_valid;
  logic [29:0]          ph_psi;
  rope_pkg::rope_side_t ph_side;
  logic                 tr_valid;
  logic signed [16:0]   tr_cos, tr_sin;
  rope_pkg::rope_side_t tr_side;

  assign busy = 1'b0;

  rope_phase #(
    .HALF_DIM (HALF_DIM),
    .ROPE_BASE(ROPE_BASE)
  ) u_phase (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(start & ~busy),
    .item_i (item_i),
    .valid_o(ph_valid),
    .psi_o  (ph_psi),
    .side_o (ph_side)
  );

  rope_trig u_trig (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(ph_valid),
    .psi_i  (ph_psi),
    .side_i (ph_side),
    .valid_o(tr_valid),
    .cos_o  (tr_cos),
    .sin_o  (tr_sin),
    .side_o (tr_side)
  );

  rope_rotate u_rotate (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (tr_valid),
    .cos_i   (tr_cos),
    .sin_i   (tr_sin),
    .side_i  (tr_side),
    .valid_o (result_valid_o),
    .result_o(result_o)
  );

endmodule

// ===== sv/rope_phase.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rope_phase
// Frequency lookup, position times frequency modulo one turn, and octant
// fold of the phase. Four register stages.
// ----------------------------------------------------------------------------
module rope_phase #(
  parameter int unsigned HALF_DIM  = 64,
  parameter int unsigned ROPE_BASE = 10000
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  rope_pkg::rope_in_t   item_i,
  output logic                 valid_o,
  output logic [29:0]          psi_o,
  output rope_pkg::rope_side_t side_o
);

  localparam logic [63:0] LIMIT = rope_pkg::ONE48 / ROPE_BASE;
  localparam logic [63:0] RATIO = rope_pkg::rope_ratio(HALF_DIM, LIMIT);

  logic [39:0] freq_tab [rope_pkg::TAB_DEPTH];

  for (genvar g = 0; g < rope_pkg::TAB_DEPTH; g++) begin : g_tab
    localparam logic [39:0] ENTRY = rope_pkg::rope_freq(g, HALF_DIM, RATIO);
    assign freq_tab[g] = ENTRY;
  end

  logic               v1_q, v2_q, v3_q, v4_q;
  logic [19:0]        pos1_q;
  logic [39:0]        freq1_q;
  logic signed [15:0] xe1_q, xo1_q, xe2_q, xo2_q, xe3_q, xo3_q;
  logic [39:0]        pp_lo_d, pp_lo_q;
  logic [39:0]        pp_hi_full;
  logic [19:0]        pp_hi_d, pp_hi_q;
  logic [39:0]        sum_d;
  logic [31:0]        phase_q;
  logic [29:0]        phi;
  logic [30:0]        refl;
  logic [29:0]        psi_d, psi_q;
  rope_pkg::rope_side_t side_d, side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  assign pp_lo_d    = 40'(pos1_q) * 40'(freq1_q[19:0]);
  assign pp_hi_full = 40'(pos1_q) * 40'(freq1_q[39:20]);
  assign pp_hi_d    = pp_hi_full[19:0];
  assign sum_d      = pp_lo_q + {pp_hi_q, 20'd0};

  always_comb begin
    phi           = phase_q[29:0];
    refl          = {1'b1, 30'd0} - {1'b0, phi};
    side_d.quad   = rope_pkg::rope_quad_e'(phase_q[31:30]);
    side_d.swap   = phi[29];
    side_d.x_even = xe3_q;
    side_d.x_odd  = xo3_q;
    psi_d         = phi[29] ? refl[29:0] : phi;
  end

  always_ff @(posedge clk_i) begin
    pos1_q  <= item_i.position;
    freq1_q <= freq_tab[item_i.pair_index];
    xe1_q   <= item_i.x_even;
    xo1_q   <= item_i.x_odd;
    pp_lo_q <= pp_lo_d;
    pp_hi_q <= pp_hi_d;
    xe2_q   <= xe1_q;
    xo2_q   <= xo1_q;
    phase_q <= sum_d[39:8];
    xe3_q   <= xe2_q;
    xo3_q   <= xo2_q;
    psi_q   <= psi_d;
    side_q  <= side_d;
  end

  assign valid_o = v4_q;
  assign psi_o   = psi_q;
  assign side_o  = side_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> psi_o <= 30'h2000_0000)
    else $error("folded angle beyond one octant");

endmodule

// ===== sv/rope_horner_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rope_horner_step
// One Horner step for the sin and cos lanes: t = 1 - (x2*t)/k, with the
// constant divide done as a reciprocal multiply. Two register stages.
// ----------------------------------------------------------------------------
module rope_horner_step #(
  parameter int unsigned SIN_DIV = 6,
  parameter int unsigned COS_DIV = 12
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  rope_pkg::rope_trig_t st_i,
  output logic                 valid_o,
  output rope_pkg::rope_trig_t st_o
);

  // exact floor divide for 30-bit dividends
  localparam int unsigned SIN_SHIFT = 30 + $clog2(SIN_DIV);
  localparam int unsigned COS_SHIFT = 30 + $clog2(COS_DIV);
  localparam logic [31:0] SIN_RECIP =
    32'(((64'd1 << SIN_SHIFT) + 64'(SIN_DIV) - 64'd1) / 64'(SIN_DIV));
  localparam logic [31:0] COS_RECIP =
    32'(((64'd1 << COS_SHIFT) + 64'(COS_DIV) - 64'd1) / 64'(COS_DIV));

  logic                 va_q, vb_q;
  logic [60:0]          ps, pc;
  logic [29:0]          vs_q, vc_q;
  rope_pkg::rope_trig_t sa_q, st_d, st_q;
  logic [61:0]          qps, qpc, qss, qsc;

  assign ps = 61'(st_i.x2) * 61'(st_i.t_sin);
  assign pc = 61'(st_i.x2) * 61'(st_i.t_cos);

  always_comb begin
    qps        = 62'(vs_q) * 62'(SIN_RECIP);
    qpc        = 62'(vc_q) * 62'(COS_RECIP);
    qss        = qps >> SIN_SHIFT;
    qsc        = qpc >> COS_SHIFT;
    st_d       = sa_q;
    st_d.t_sin = rope_pkg::ONE30 - {1'b0, qss[29:0]};
    st_d.t_cos = rope_pkg::ONE30 - {1'b0, qsc[29:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      va_q <= valid_i;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sa_q <= st_i;
    vs_q <= ps[59:30];
    vc_q <= pc[59:30];
    st_q <= st_d;
  end

  assign valid_o = vb_q;
  assign st_o    = st_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(valid_i, 2) |-> valid_o)
    else $error("item lost in Horner step");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (st_o.t_sin <= rope_pkg::ONE30) && (st_o.t_sin > (rope_pkg::ONE30 >> 1))
             && (st_o.t_cos <= rope_pkg::ONE30) && (st_o.t_cos > (rope_pkg::ONE30 >> 1)))
    else $error("Horner term out of range");

endmodule

// ===== sv/rope_trig.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rope_trig
// Octant angle to radians, x squared, four shared Horner steps, last sin/cos
// terms, rounding to Q1.15 and quadrant signs. Thirteen register stages.
// ----------------------------------------------------------------------------
module rope_trig (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic [29:0]          psi_i,
  input  rope_pkg::rope_side_t side_i,
  output logic                 valid_o,
  output logic signed [16:0]   cos_o,
  output logic signed [16:0]   sin_o,
  output rope_pkg::rope_side_t side_o
);

  localparam int unsigned NSTEP = 4;
  localparam int unsigned SIN_DIVS [NSTEP] = '{72, 42, 20, 6};
  localparam int unsigned COS_DIVS [NSTEP] = '{90, 56, 30, 12};

  logic                 v1_q, v2_q, vf1_q, vf2_q, vf3_q;
  logic [61:0]          ang_prod;
  logic [29:0]          x1_q;
  rope_pkg::rope_side_t side1_q;
  logic [59:0]          sq;
  rope_pkg::rope_trig_t st2_d, st2_q;

  rope_pkg::rope_trig_t chain [NSTEP+1];
  logic [NSTEP:0]       chain_v;

  logic [60:0]          pf_cos, pf_sin;
  logic [29:0]          vc_f1_q, s_f1_q, s_f2_q;
  rope_pkg::rope_side_t side_f1_q, side_f2_q;
  logic [30:0]          c_f2_d, c_f2_q;
  logic [30:0]          s_sum, c_sum;
  logic [15:0]          s0, c0, mag_s, mag_c;
  logic signed [16:0]   ps_s, ps_c;
  logic signed [16:0]   cos_d, sin_d, cos_q, sin_q;
  rope_pkg::rope_side_t side_f3_q;
  logic signed [35:0]   mag2;

  assign ang_prod = 62'(psi_i) * 62'(rope_pkg::TWO_PI_Q29);
  assign sq       = 60'(x1_q) * 60'(x1_q);

  always_comb begin
    st2_d.side  = side1_q;
    st2_d.x     = x1_q;
    st2_d.x2    = sq[59:30];
    st2_d.t_sin = rope_pkg::ONE30;
    st2_d.t_cos = rope_pkg::ONE30;
  end

  assign chain[0]   = st2_q;
  assign chain_v[0] = v2_q;

  for (genvar g = 0; g < NSTEP; g++) begin : g_step
    rope_horner_step #(
      .SIN_DIV(SIN_DIVS[g]),
      .COS_DIV(COS_DIVS[g])
    ) u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(chain_v[g]),
      .st_i   (chain[g]),
      .valid_o(chain_v[g+1]),
      .st_o   (chain[g+1])
    );
  end

  // last cos term divides by two; sin takes its final factor of x
  assign pf_cos = 61'(chain[NSTEP].x2) * 61'(chain[NSTEP].t_cos);
  assign pf_sin = 61'(chain[NSTEP].x) * 61'(chain[NSTEP].t_sin);
  assign c_f2_d = rope_pkg::ONE30 - {2'b00, vc_f1_q[29:1]};

  always_comb begin
    s_sum = {1'b0, s_f2_q} + rope_pkg::HALF_LSB15;
    c_sum = c_f2_q + rope_pkg::HALF_LSB15;
    s0    = s_sum[30:15];
    c0    = c_sum[30:15];
    mag_s = side_f2_q.swap ? c0 : s0;
    mag_c = side_f2_q.swap ? s0 : c0;
    ps_s  = $signed({1'b0, mag_s});
    ps_c  = $signed({1'b0, mag_c});
    case (side_f2_q.quad)
      rope_pkg::QUAD_0: begin
        cos_d = ps_c;
        sin_d = ps_s;
      end
      rope_pkg::QUAD_1: begin
        cos_d = -ps_s;
        sin_d = ps_c;
      end
      rope_pkg::QUAD_2: begin
        cos_d = -ps_c;
        sin_d = -ps_s;
      end
      rope_pkg::QUAD_3: begin
        cos_d = ps_s;
        sin_d = -ps_c;
      end
      default: begin
        cos_d = ps_c;
        sin_d = ps_s;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      vf1_q <= 1'b0;
      vf2_q <= 1'b0;
      vf3_q <= 1'b0;
    end else begin
      v1_q  <= valid_i;
      v2_q  <= v1_q;
      vf1_q <= chain_v[NSTEP];
      vf2_q <= vf1_q;
      vf3_q <= vf2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    x1_q      <= ang_prod[60:31];
    side1_q   <= side_i;
    st2_q     <= st2_d;
    vc_f1_q   <= pf_cos[59:30];
    s_f1_q    <= pf_sin[59:30];
    side_f1_q <= chain[NSTEP].side;
    c_f2_q    <= c_f2_d;
    s_f2_q    <= s_f1_q;
    side_f2_q <= side_f1_q;
    cos_q     <= cos_d;
    sin_q     <= sin_d;
    side_f3_q <= side_f2_q;
  end

  assign valid_o = vf3_q;
  assign cos_o   = cos_q;
  assign sin_o   = sin_q;
  assign side_o  = side_f3_q;

  assign mag2 = 36'(cos_q) * 36'(cos_q) + 36'(sin_q) * 36'(sin_q);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (mag2 >= 36'sh3FFE_0000) && (mag2 <= 36'sh4002_0000))
    else $error("cos^2 + sin^2 far from one");

endmodule

// ===== sv/rope_rotate.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rope_rotate
// Rotates the element pair by (cos, sin): products, sums, round half up and
// saturate to Q3.12. Three register stages.
// ----------------------------------------------------------------------------
module rope_rotate (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic signed [16:0]   cos_i,
  input  logic signed [16:0]   sin_i,
  input  rope_pkg::rope_side_t side_i,
  output logic                 valid_o,
  output rope_pkg::rope_out_t  result_o
);

  function automatic logic signed [15:0] sat16(input logic signed [33:0] v);
    if (v > 34'sd32767) begin
      return 16'sh7fff;
    end
    if (v < -34'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  logic                v1_q, v2_q, v3_q;
  logic signed [32:0]  p_ec_d, p_os_d, p_oc_d, p_es_d;
  logic signed [32:0]  p_ec_q, p_os_q, p_oc_q, p_es_q;
  logic signed [33:0]  acc_e_d, acc_o_d, acc_e_q, acc_o_q;
  logic signed [33:0]  te, to;
  rope_pkg::rope_out_t res_d, res_q;

  assign p_ec_d = 33'(side_i.x_even) * 33'(cos_i);
  assign p_os_d = 33'(side_i.x_odd) * 33'(sin_i);
  assign p_oc_d = 33'(side_i.x_odd) * 33'(cos_i);
  assign p_es_d = 33'(side_i.x_even) * 33'(sin_i);

  assign acc_e_d = 34'(p_ec_q) + 34'(p_os_q);
  assign acc_o_d = 34'(p_oc_q) - 34'(p_es_q);

  always_comb begin
    te           = acc_e_q + 34'sd16384;
    to           = acc_o_q + 34'sd16384;
    res_d.y_even = sat16(te >>> 15);
    res_d.y_odd  = sat16(to >>> 15);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p_ec_q  <= p_ec_d;
    p_os_q  <= p_os_d;
    p_oc_q  <= p_oc_d;
    p_es_q  <= p_es_d;
    acc_e_q <= acc_e_d;
    acc_o_q <= acc_o_d;
    res_q   <= res_d;
  end

  assign valid_o  = v3_q;
  assign result_o = res_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(valid_i, 3) |-> valid_o)
    else $error("item lost in rotate stages");

endmodule
